>>> rtl/core/grid_maze_router_core_defines.svh
// ----------------------------------------------------------------------------
// grid maze router assertion macros
// shared concurrent assertion forms for the router rtl
// ----------------------------------------------------------------------------
`ifndef GRID_MAZE_ROUTER_CORE_DEFINES_SVH
`define GRID_MAZE_ROUTER_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define GMR_ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define GMR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/gmr_pkg.sv
// ----------------------------------------------------------------------------
// gmr_pkg
// types and codes shared by the grid maze router
// ----------------------------------------------------------------------------
package gmr_pkg;

    localparam logic [1:0] FN_WRITE = 2'd0;
    localparam logic [1:0] FN_RUN   = 2'd1;
    localparam logic [1:0] FN_READ  = 2'd2;

    localparam logic [1:0] KIND_OBST  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0] func;
        logic [4:0] cell_x;
        logic [4:0] cell_y;
        logic [1:0] cell_kind;
        logic [9:0] path_index;
    } t_in;

    typedef struct packed {
        logic        found;
        logic [10:0] path_length;
        logic [4:0]  step_x;
        logic [4:0]  step_y;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLR,
        ST_POP,
        ST_EXP,
        ST_BT,
        ST_BTEND,
        ST_RD,
        ST_RESP
    } t_state;

endpackage

>>> rtl/core/gmr_ram.sv
// ----------------------------------------------------------------------------
// gmr_ram
// simple dual port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module gmr_ram #(
    parameter int DW = 12,
    parameter int AW = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/grid_maze_router_core.sv
// ----------------------------------------------------------------------------
// grid_maze_router_core
// lee maze router: breadth-first wavefront over a cell memory, then backtrace
// ----------------------------------------------------------------------------
// channel   dir  handshake                  payload
// in        in   i_in_valid / o_in_ready    i_in_data  (t_in)
// out       out  o_out_valid / i_out_ready  o_out_data (t_out)
// cfg       in   i_cfg_we                   i_cfg_idx, i_cfg_data
//
// write and func 3 go from idle to the response state; read passes through ST_RD first (registered list memory read)
// run: a clearing pass over every address of the cell memory, then the wavefront
//   expands each dequeued cell and the backtrace walks each path step on the one cell port
// reset is synchronous active low; the memories are not cleared by it
// a stalled result sits in the output register while the next item is taken
// ----------------------------------------------------------------------------
`include "grid_maze_router_core_defines.svh"

module grid_maze_router_core #(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  gmr_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output gmr_pkg::t_out  o_out_data,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [5:0]     i_cfg_data
);

    localparam int XW    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW    = XW + YW;
    localparam int DW    = AW + 1;
    localparam int LW    = AW + DW;
    localparam int CELLS = 2**AW;
    localparam int WCW   = $clog2(MAX_WIDTH + 1);
    localparam int HCW   = $clog2(MAX_HEIGHT + 1);
    localparam logic [DW-1:0] UNSEEN  = '1;
    localparam logic [DW-1:0] BLOCKED = UNSEEN - DW'(1);

    gmr_pkg::t_state r_state, n_state;
    logic [1:0]    r_k, n_k;
    logic [AW:0]   r_cnt, n_cnt;
    logic          r_cv, n_cv;
    logic [AW-1:0] r_ca, n_ca;
    logic [AW:0]   r_head, n_head, r_tail, n_tail;
    logic          r_pv, n_pv;
    logic [AW-1:0] r_pa, n_pa;
    logic [DW-1:0] r_pd, n_pd;
    logic [XW-1:0] r_curx, n_curx;
    logic [YW-1:0] r_cury, n_cury;
    logic [DW-1:0] r_curd, n_curd;
    logic [AW-1:0] r_bc, n_bc;
    logic [DW-1:0] r_best, n_best;
    logic [AW-1:0] r_next, n_next;
    logic          r_found, n_found;
    logic [AW:0]   r_count, n_count;
    logic [XW-1:0] r_sx, n_sx, r_ex, n_ex;
    logic [YW-1:0] r_sy, n_sy, r_ey, n_ey;
    logic [5:0]    r_w, n_w, r_h, n_h;
    logic          r_hit, n_hit;
    logic [4:0]    r_stepx, n_stepx, r_stepy, n_stepy;
    logic          r_ov, n_ov;
    gmr_pkg::t_out r_od, n_od;

    logic          cm_we;
    logic [AW-1:0] cm_wa, cm_ra;
    logic [DW:0]   cm_wd, cm_rd;
    logic          ls_we;
    logic [AW-1:0] ls_wa, ls_ra;
    logic [LW-1:0] ls_wd, ls_rd;

    logic [WCW-1:0] eff_w;
    logic [HCW-1:0] eff_h;
    logic           in_fire;
    logic [XW-1:0]  bx;
    logic [YW-1:0]  by;
    logic [DW-1:0]  bd;
    logic           nb_valid;
    logic [AW-1:0]  nb_addr;
    logic [AW-1:0]  ls_addr;
    logic           cm_obst;
    logic [DW-1:0]  cm_dist;
    logic [DW-1:0]  bt_best;
    logic [AW-1:0]  bt_next;
    logic           se_ok;

    gmr_ram #(.DW(DW + 1), .AW(AW)) u_cell_mem (
        .i_clk   (i_clk),
        .i_we    (cm_we),
        .i_waddr (cm_wa),
        .i_wdata (cm_wd),
        .i_raddr (cm_ra),
        .o_rdata (cm_rd)
    );

    gmr_ram #(.DW(LW), .AW(AW)) u_list_mem (
        .i_clk   (i_clk),
        .i_we    (ls_we),
        .i_waddr (ls_wa),
        .i_wdata (ls_wd),
        .i_raddr (ls_ra),
        .o_rdata (ls_rd)
    );

    // clamp grid size registers
    always_comb begin
        if (r_w == '0) begin
            eff_w = WCW'(1);
        end else if (32'(r_w) > MAX_WIDTH) begin
            eff_w = WCW'(MAX_WIDTH);
        end else begin
            eff_w = WCW'(r_w);
        end
        if (r_h == '0) begin
            eff_h = HCW'(1);
        end else if (32'(r_h) > MAX_HEIGHT) begin
            eff_h = HCW'(MAX_HEIGHT);
        end else begin
            eff_h = HCW'(r_h);
        end
    end

    assign o_in_ready = (r_state == gmr_pkg::ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign ls_addr    = ls_rd[LW-1 -: AW];
    assign cm_obst    = cm_rd[DW];
    assign cm_dist    = cm_rd[DW-1:0];
    assign se_ok      = (WCW'(r_sx) < eff_w) && (HCW'(r_sy) < eff_h) &&
                        (WCW'(r_ex) < eff_w) && (HCW'(r_ey) < eff_h);

    // cell whose neighbors are visited
    always_comb begin
        if (r_state == gmr_pkg::ST_BT) begin
            bx = r_bc[XW-1:0];
            by = r_bc[AW-1:XW];
            bd = r_curd;
        end else if (r_state == gmr_pkg::ST_EXP && r_k == 2'd0) begin
            bx = ls_addr[XW-1:0];
            by = ls_addr[AW-1:XW];
            bd = ls_rd[DW-1:0];
        end else begin
            bx = r_curx;
            by = r_cury;
            bd = r_curd;
        end
        case (r_k)
            2'd0: begin
                nb_valid = (WCW'(bx) + WCW'(1)) < eff_w;
                nb_addr  = {by, bx + XW'(1)};
            end
            2'd1: begin
                nb_valid = (bx != '0);
                nb_addr  = {by, bx - XW'(1)};
            end
            2'd2: begin
                nb_valid = (HCW'(by) + HCW'(1)) < eff_h;
                nb_addr  = {by + YW'(1), bx};
            end
            default: begin
                nb_valid = (by != '0);
                nb_addr  = {by - YW'(1), bx};
            end
        endcase
    end

    // backtrace candidate compare
    always_comb begin
        bt_best = r_best;
        bt_next = r_next;
        if (r_pv && cm_dist < BLOCKED && cm_dist < r_best) begin
            bt_best = cm_dist;
            bt_next = r_pa;
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_cnt   = r_cnt;
        n_cv    = 1'b0;
        n_ca    = r_ca;
        n_head  = r_head;
        n_tail  = r_tail;
        n_pv    = 1'b0;
        n_pa    = r_pa;
        n_pd    = r_pd;
        n_curx  = r_curx;
        n_cury  = r_cury;
        n_curd  = r_curd;
        n_bc    = r_bc;
        n_best  = r_best;
        n_next  = r_next;
        n_found = r_found;
        n_count = r_count;
        n_sx    = r_sx;
        n_sy    = r_sy;
        n_ex    = r_ex;
        n_ey    = r_ey;
        n_w     = r_w;
        n_h     = r_h;
        n_hit   = r_hit;
        n_stepx = r_stepx;
        n_stepy = r_stepy;
        n_ov    = r_ov && !i_out_ready;
        n_od    = r_od;
        cm_we   = 1'b0;
        cm_wa   = r_ca;
        cm_wd   = {cm_obst, UNSEEN};
        cm_ra   = nb_addr;
        ls_we   = 1'b0;
        ls_wa   = r_tail[AW-1:0];
        ls_wd   = {r_pa, r_pd};
        ls_ra   = r_head[AW-1:0];

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gmr_pkg::CFG_WIDTH:  n_w = i_cfg_data;
                gmr_pkg::CFG_HEIGHT: n_h = i_cfg_data;
                default: ;
            endcase
        end

        // clearing pass write-back, start seeded at distance zero
        if (r_state == gmr_pkg::ST_CLR && r_cv) begin
            cm_we = 1'b1;
            cm_wa = r_ca;
            cm_wd = {cm_obst, (r_ca == {r_sy, r_sx}) ? DW'(0) : UNSEEN};
        end

        // wavefront mark of the pending neighbor
        if ((r_state == gmr_pkg::ST_POP || r_state == gmr_pkg::ST_EXP) && r_pv &&
            cm_dist == UNSEEN) begin
            cm_we = 1'b1;
            cm_wa = r_pa;
            cm_wd = {cm_obst, cm_obst ? BLOCKED : r_pd};
            if (!cm_obst) begin
                ls_we  = 1'b1;
                ls_wa  = r_tail[AW-1:0];
                ls_wd  = {r_pa, r_pd};
                n_tail = r_tail + (AW+1)'(1);
            end
        end

        if (r_state == gmr_pkg::ST_BT || r_state == gmr_pkg::ST_BTEND) begin
            n_best = bt_best;
            n_next = bt_next;
        end

        unique case (r_state)
            gmr_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_stepx = '0;
                    n_stepy = '0;
                    n_state = gmr_pkg::ST_RESP;
                    case (i_in_data.func)
                        gmr_pkg::FN_WRITE: begin
                            if (32'(i_in_data.cell_x) < MAX_WIDTH &&
                                32'(i_in_data.cell_y) < MAX_HEIGHT) begin
                                cm_we = 1'b1;
                                cm_wa = {YW'(i_in_data.cell_y), XW'(i_in_data.cell_x)};
                                cm_wd = {i_in_data.cell_kind == gmr_pkg::KIND_OBST, UNSEEN};
                                if (i_in_data.cell_kind == gmr_pkg::KIND_START) begin
                                    n_sx = XW'(i_in_data.cell_x);
                                    n_sy = YW'(i_in_data.cell_y);
                                end else if (i_in_data.cell_kind == gmr_pkg::KIND_END) begin
                                    n_ex = XW'(i_in_data.cell_x);
                                    n_ey = YW'(i_in_data.cell_y);
                                end
                            end
                        end
                        gmr_pkg::FN_RUN: begin
                            n_found = 1'b0;
                            n_count = '0;
                            if (se_ok) begin
                                n_cnt   = '0;
                                n_state = gmr_pkg::ST_CLR;
                            end
                        end
                        gmr_pkg::FN_READ: begin
                            ls_ra   = AW'(i_in_data.path_index);
                            n_hit   = 32'(i_in_data.path_index) < 32'(r_count);
                            n_state = gmr_pkg::ST_RD;
                        end
                        default: ;
                    endcase
                end
            end
            gmr_pkg::ST_RD: begin
                if (r_hit) begin
                    n_stepx = 5'(ls_addr[XW-1:0]);
                    n_stepy = 5'(ls_addr[AW-1:XW]);
                end
                n_state = gmr_pkg::ST_RESP;
            end
            gmr_pkg::ST_CLR: begin
                if (32'(r_cnt) < CELLS) begin
                    cm_ra = r_cnt[AW-1:0];
                    n_cv  = 1'b1;
                    n_ca  = r_cnt[AW-1:0];
                    n_cnt = r_cnt + (AW+1)'(1);
                end else begin
                    ls_we   = 1'b1;
                    ls_wa   = '0;
                    ls_wd   = {r_sy, r_sx, DW'(0)};
                    n_head  = '0;
                    n_tail  = (AW+1)'(1);
                    n_state = gmr_pkg::ST_POP;
                end
            end
            gmr_pkg::ST_POP: begin
                if (r_head != r_tail) begin
                    ls_ra   = r_head[AW-1:0];
                    n_head  = r_head + (AW+1)'(1);
                    n_k     = 2'd0;
                    n_state = gmr_pkg::ST_EXP;
                end else if (!r_pv) begin
                    n_state = gmr_pkg::ST_RESP;
                end
            end
            gmr_pkg::ST_EXP: begin
                if (r_k == 2'd0) begin
                    n_curx = bx;
                    n_cury = by;
                    n_curd = bd;
                end
                if (r_k == 2'd0 && {by, bx} == {r_ey, r_ex}) begin
                    n_found = 1'b1;
                    n_bc    = {r_ey, r_ex};
                    n_state = gmr_pkg::ST_BT;
                end else begin
                    n_pv = nb_valid;
                    n_pa = nb_addr;
                    n_pd = bd + DW'(1);
                    n_k  = r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        n_state = gmr_pkg::ST_POP;
                    end
                end
            end
            gmr_pkg::ST_BT: begin
                if (r_k == 2'd0) begin
                    n_best = BLOCKED;
                    n_next = r_bc;
                end
                if (r_k == 2'd0 && (r_bc == {r_sy, r_sx} || 32'(r_count) >= CELLS)) begin
                    n_state = gmr_pkg::ST_RESP;
                end else begin
                    n_pv = nb_valid;
                    n_pa = nb_addr;
                    n_k  = r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        n_state = gmr_pkg::ST_BTEND;
                    end
                end
            end
            gmr_pkg::ST_BTEND: begin
                if (bt_next == r_bc) begin
                    n_state = gmr_pkg::ST_RESP;
                end else begin
                    ls_we   = 1'b1;
                    ls_wa   = r_count[AW-1:0];
                    ls_wd   = {bt_next, DW'(0)};
                    n_count = r_count + (AW+1)'(1);
                    n_bc    = bt_next;
                    n_k     = 2'd0;
                    n_state = gmr_pkg::ST_BT;
                end
            end
            gmr_pkg::ST_RESP: begin
                if (!r_ov || i_out_ready) begin
                    n_ov    = 1'b1;
                    n_od    = '{found: r_found, path_length: 11'(r_count),
                                step_x: r_stepx, step_y: r_stepy};
                    n_state = gmr_pkg::ST_IDLE;
                end
            end
            default: n_state = gmr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gmr_pkg::ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_pv    <= 1'b0;
            r_cv    <= 1'b0;
            r_found <= 1'b0;
            r_count <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_ex    <= '0;
            r_ey    <= '0;
            r_w     <= 6'd32;
            r_h     <= 6'd32;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_pv    <= n_pv;
            r_cv    <= n_cv;
            r_found <= n_found;
            r_count <= n_count;
            r_sx    <= n_sx;
            r_sy    <= n_sy;
            r_ex    <= n_ex;
            r_ey    <= n_ey;
            r_w     <= n_w;
            r_h     <= n_h;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_cnt   <= n_cnt;
        r_ca    <= n_ca;
        r_pa    <= n_pa;
        r_pd    <= n_pd;
        r_curx  <= n_curx;
        r_cury  <= n_cury;
        r_curd  <= n_curd;
        r_bc    <= n_bc;
        r_best  <= n_best;
        r_next  <= n_next;
        r_hit   <= n_hit;
        r_stepx <= n_stepx;
        r_stepy <= n_stepy;
        r_od    <= n_od;
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

    `GMR_ASSERT_ALWAYS(a_queue_order, i_clk, i_rst_n, r_head <= r_tail, "queue head passed tail")
    `GMR_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, in_fire, r_state != gmr_pkg::ST_IDLE, "transfer left block idle")
    `GMR_ASSERT_ALWAYS(a_path_found, i_clk, i_rst_n, (r_count == '0) || r_found, "path without found")

endmodule
